@@ hw/rtl/crc_checked_frame_deframer_assert.svh @@
// assertion macros shared by the deframer modules
`ifndef CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define DFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define DFR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define DFR_ASSERT(lbl, prop, msg)
`define DFR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/dfr_pkg.sv @@
package dfr_pkg;

	localparam int HEADER_BYTES = 44;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	localparam logic [2:0] ST_FRAME_OK    = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_BAD_KIND    = 3'd3;
	localparam logic [2:0] ST_TOO_LONG    = 3'd4;
	localparam logic [2:0] ST_CRC_BAD     = 3'd5;
	localparam logic [2:0] ST_READ_OK     = 3'd6;
	localparam logic [2:0] ST_READ_RANGE  = 3'd7;

	localparam logic [2:0] REG_MAGIC       = 3'd0;
	localparam logic [2:0] REG_VERSION_MIN = 3'd1;
	localparam logic [2:0] REG_VERSION_MAX = 3'd2;
	localparam logic [2:0] REG_KIND_MAX    = 3'd3;
	localparam logic [2:0] REG_PAYLOAD_CAP = 3'd4;

	// one queued request for the back end: a ram write, a ram read, a result
	typedef struct packed {
		logic        wr;
		logic        rd;
		logic        res;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [2:0]  status;
		logic [15:0] kind;
		logic [15:0] version;
		logic [31:0] flags;
		logic [63:0] seq;
		logic [63:0] epoch;
		logic [63:0] boot;
		logic [12:0] len;
		logic [31:0] crc;
	} entry_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/dfr_front.sv @@
module dfr_front import dfr_pkg::*; #(
	parameter int PAYLOAD_DEPTH = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         opcode,
	input  logic [7:0]   data_byte,
	input  logic [11:0]  read_index,
	input  logic         q_full,
	output logic         push,
	output entry_t       push_entry
);

	localparam int PW = $clog2(HEADER_BYTES + PAYLOAD_DEPTH);
	localparam int LW = $clog2(PAYLOAD_DEPTH + 1);

	logic [31:0] magic_q;
	logic [15:0] vmin_q, vmax_q, kmax_q;
	logic [12:0] maxp_q;

	logic [PW-1:0] pos_q;
	logic [15:0]   version_q, kind_q;
	logic [31:0]   flags_q, len_q, hcrc_q, crc_q;
	logic [63:0]   seq_q, epoch_q, boot_q;
	logic [LW-1:0] dlen_q;
	logic          halted_q, magic_bad_q;

	logic          acc, stream;
	logic [7:0]    cbyte;
	logic [31:0]   crc_next, hcrc_full, limit, pidx;
	logic          magic_bad_n, err, ok;
	logic [2:0]    err_code;

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;
	assign stream = acc && !opcode && !halted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			vmin_q <= 16'd1;
			vmax_q <= 16'd1;
			kmax_q <= 16'd22;
			maxp_q <= 13'd4096;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAGIC:       magic_q <= cfg_data;
				REG_VERSION_MIN: vmin_q <= cfg_data[15:0];
				REG_VERSION_MAX: vmax_q <= cfg_data[15:0];
				REG_KIND_MAX:    kmax_q <= cfg_data[15:0];
				REG_PAYLOAD_CAP: maxp_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cbyte = (pos_q >= PW'(40) && pos_q < PW'(HEADER_BYTES)) ? 8'd0 : data_byte;
		crc_next = crc_byte(crc_q, cbyte);
		hcrc_full = {data_byte, hcrc_q[23:0]};
		magic_bad_n = magic_bad_q;
		if (pos_q < PW'(4) && magic_q[8*pos_q[1:0] +: 8] != data_byte)
			magic_bad_n = 1'b1;
		limit = ({19'd0, maxp_q} < 32'(PAYLOAD_DEPTH)) ? {19'd0, maxp_q} : 32'(PAYLOAD_DEPTH);
		pidx = 32'(pos_q) - 32'(HEADER_BYTES);
		err = 1'b0;
		ok = 1'b0;
		err_code = ST_CRC_BAD;
		if (pos_q < PW'(HEADER_BYTES)) begin
			if (pos_q == PW'(3) && magic_bad_n) begin
				err = 1'b1;
				err_code = ST_BAD_MAGIC;
			end else if (pos_q == PW'(HEADER_BYTES - 1)) begin
				if (version_q < vmin_q || version_q > vmax_q) begin
					err = 1'b1;
					err_code = ST_BAD_VERSION;
				end else if (kind_q == 16'd0 || kind_q > kmax_q) begin
					err = 1'b1;
					err_code = ST_BAD_KIND;
				end else if (len_q > limit) begin
					err = 1'b1;
					err_code = ST_TOO_LONG;
				end else if (len_q == 32'd0) begin
					if (~crc_next == hcrc_full) ok = 1'b1;
					else err = 1'b1;
				end
			end
		end else if (pidx + 32'd1 >= len_q) begin
			if (~crc_next == hcrc_q) ok = 1'b1;
			else err = 1'b1;
		end
	end

	always_comb begin
		push_entry = '0;
		push = 1'b0;
		if (acc && opcode) begin
			push = 1'b1;
			push_entry.res = 1'b1;
			push_entry.addr = {4'd0, read_index};
			if (32'(read_index) < 32'(dlen_q) && 32'(read_index) < 32'(PAYLOAD_DEPTH)) begin
				push_entry.rd = 1'b1;
				push_entry.status = ST_READ_OK;
			end else begin
				push_entry.status = ST_READ_RANGE;
			end
		end else if (stream) begin
			if (pos_q >= PW'(HEADER_BYTES)) begin
				push_entry.wr = 1'b1;
				push_entry.addr = pidx[15:0];
				push_entry.wdata = data_byte;
			end
			if (err) begin
				push_entry.res = 1'b1;
				push_entry.status = err_code;
			end else if (ok) begin
				push_entry.res = 1'b1;
				push_entry.status = ST_FRAME_OK;
				push_entry.kind = kind_q;
				push_entry.version = version_q;
				push_entry.flags = flags_q;
				push_entry.seq = seq_q;
				push_entry.epoch = epoch_q;
				push_entry.boot = boot_q;
				push_entry.len = len_q[12:0];
				push_entry.crc = (pos_q < PW'(HEADER_BYTES)) ? hcrc_full : hcrc_q;
			end
			push = push_entry.wr || push_entry.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= '1;
			magic_bad_q <= 1'b0;
			halted_q <= 1'b0;
			dlen_q <= '0;
		end else if (stream) begin
			if (err) begin
				halted_q <= 1'b1;
			end else if (ok) begin
				pos_q <= '0;
				crc_q <= '1;
				magic_bad_q <= 1'b0;
				dlen_q <= LW'(len_q);
			end else begin
				pos_q <= pos_q + PW'(1);
				crc_q <= crc_next;
				magic_bad_q <= magic_bad_n;
			end
		end
	end

	// header lanes; every lane is rewritten before the fields are used
	always_ff @(posedge clk) begin
		if (stream && pos_q < PW'(HEADER_BYTES)) begin
			if (pos_q < PW'(4)) begin
			end else if (pos_q < PW'(6)) begin
				version_q[8*pos_q[0] +: 8] <= data_byte;
			end else if (pos_q < PW'(8)) begin
				kind_q[8*pos_q[0] +: 8] <= data_byte;
			end else if (pos_q < PW'(12)) begin
				flags_q[8*pos_q[1:0] +: 8] <= data_byte;
			end else if (pos_q < PW'(20)) begin
				seq_q[8*3'(pos_q - PW'(12)) +: 8] <= data_byte;
			end else if (pos_q < PW'(28)) begin
				epoch_q[8*3'(pos_q - PW'(20)) +: 8] <= data_byte;
			end else if (pos_q < PW'(36)) begin
				boot_q[8*3'(pos_q - PW'(28)) +: 8] <= data_byte;
			end else if (pos_q < PW'(40)) begin
				len_q[8*pos_q[1:0] +: 8] <= data_byte;
			end else begin
				hcrc_q[8*pos_q[1:0] +: 8] <= data_byte;
			end
		end
	end

	`include "crc_checked_frame_deframer_assert.svh"

	`DFR_ASSERT_IMPL(a_halt_sticky, halted_q, ##1 halted_q, "halt flag cleared")

endmodule

@@ hw/rtl/dfr_queue.sv @@
module dfr_queue import dfr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	output logic   head_valid,
	output entry_t head,
	input  logic   pop
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	entry_t          slots_q [QUEUE_DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign full = cnt_q == (AW+1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head = slots_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wp_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + AW'(1);
			if (pop) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	`include "crc_checked_frame_deframer_assert.svh"

	`DFR_ASSERT(a_no_overflow, !(push && full), "request pushed into full queue")
	`DFR_ASSERT(a_no_underflow, !(pop && !head_valid), "pop from empty queue")

endmodule

@@ hw/rtl/dfr_back.sv @@
module dfr_back import dfr_pkg::*; #(
	parameter int PAYLOAD_DEPTH = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  entry_t       head,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   status,
	output logic [15:0]  msg_kind,
	output logic [15:0]  proto_version,
	output logic [31:0]  frame_flags,
	output logic [63:0]  seq_number,
	output logic [63:0]  epoch_value,
	output logic [63:0]  boot_value,
	output logic [12:0]  payload_len,
	output logic [31:0]  declared_crc,
	output logic [7:0]   payload_byte
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic [7:0]  mem [PAYLOAD_DEPTH];
	logic        v_s1;
	entry_t      e_s1;
	logic [7:0]  rd_s1;
	logic        take;

	assign pop = head_valid && (!head.res || !v_s1 || out_ready);
	assign take = pop && head.res;

	always_ff @(posedge clk) begin
		if (pop && head.wr) mem[head.addr[AW-1:0]] <= head.wdata;
		if (pop && head.rd) rd_s1 <= mem[head.addr[AW-1:0]];
		if (take) e_s1 <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (take) v_s1 <= 1'b1;
		else if (out_ready) v_s1 <= 1'b0;
	end

	assign out_valid = v_s1;
	assign status = e_s1.status;
	assign msg_kind = e_s1.kind;
	assign proto_version = e_s1.version;
	assign frame_flags = e_s1.flags;
	assign seq_number = e_s1.seq;
	assign epoch_value = e_s1.epoch;
	assign boot_value = e_s1.boot;
	assign payload_len = e_s1.len;
	assign declared_crc = e_s1.crc;
	assign payload_byte = (e_s1.status == ST_READ_OK) ? rd_s1 : 8'd0;

	`include "crc_checked_frame_deframer_assert.svh"

	`DFR_ASSERT_IMPL(a_take_needs_room, take, (!v_s1 || out_ready), "result overwritten")

endmodule

@@ hw/rtl/crc_checked_frame_deframer.sv @@
// channel | direction | handshake           | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid/in_ready   | opcode, data_byte, read_index
// out     | out       | out_valid/out_ready | status .. payload_byte
// one request per cycle while in_ready is high; a result passes front classify (combinational), the
// queue slot register and the ram read / output register before it leaves
// in_ready drops only when the four-entry request queue is full
// cfg_ready is always high; reset clears control state, the payload ram is not cleared
module crc_checked_frame_deframer import dfr_pkg::*; #(
	parameter int PAYLOAD_DEPTH = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         opcode,
	input  logic [7:0]   data_byte,
	input  logic [11:0]  read_index,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   status,
	output logic [15:0]  msg_kind,
	output logic [15:0]  proto_version,
	output logic [31:0]  frame_flags,
	output logic [63:0]  seq_number,
	output logic [63:0]  epoch_value,
	output logic [63:0]  boot_value,
	output logic [12:0]  payload_len,
	output logic [31:0]  declared_crc,
	output logic [7:0]   payload_byte
);

	logic   q_full, push, head_valid, pop;
	entry_t push_entry, head;

	assign cfg_ready = 1'b1;

	dfr_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
		.clk, .arst_n, .cfg_valid, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .opcode, .data_byte, .read_index,
		.q_full, .push, .push_entry
	);

	dfr_queue u_queue (
		.clk, .arst_n, .push, .push_entry, .full(q_full),
		.head_valid, .head, .pop
	);

	dfr_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
		.clk, .arst_n, .head_valid, .head, .pop,
		.out_valid, .out_ready, .status, .msg_kind, .proto_version,
		.frame_flags, .seq_number, .epoch_value, .boot_value,
		.payload_len, .declared_crc, .payload_byte
	);

endmodule
